// ----- hdl/qjet_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// qjet_pkg
// Shared widths, register indexes, reset values and the ring control struct
// of the quaternion Julia escape-time block.
// ----------------------------------------------------------------------------
package qjet_pkg;

    // widths fixed by the ports
    localparam int FIELD_W     = 32;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int LIMIT_W     = 16;
    localparam int RADIUS_W    = 24;
    localparam int R2_W        = 2 * RADIUS_W;

    // quaternion parts held in the ring
    localparam int QUAT_PARTS = 4;
    localparam int QIDX_W     = 2;
    localparam logic [QIDX_W-1:0] PART_REAL = QIDX_W'(0);
    localparam logic [QIDX_W-1:0] PART_I    = QIDX_W'(1);
    localparam logic [QIDX_W-1:0] PART_LAST = QIDX_W'(QUAT_PARTS - 1);

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_START_REAL = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_I    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_J    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_K    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_ITER_LIMIT = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_ESC_RADIUS = 3'd5;

    // reset values
    localparam logic [FIELD_W-1:0]  START_RESET  = '0;
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 16'd5;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 24'd327680;

    // control of one ring cell
    typedef struct packed {
        logic load;   // take fresh start value and constant
        logic shift;  // take the neighbour's hand-off
        logic upd;    // hand off the updated component instead of the held one
    } t_ring_ctrl;

endpackage
`default_nettype wire

// ----- hdl/qjet_mul.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// qjet_mul
// Signed full-width multiplier that splits the second operand in two halves
// and passes both through one narrow multiplier, then recombines.
// ----------------------------------------------------------------------------
module qjet_mul #(
    parameter int COMPONENT_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [COMPONENT_WIDTH-1:0]   i_a,
    input  logic signed [COMPONENT_WIDTH-1:0]   i_b,
    output logic                                o_done,
    output logic signed [2*COMPONENT_WIDTH-1:0] o_p
);

    localparam int W  = COMPONENT_WIDTH;
    localparam int L  = W / 2;
    localparam int H  = W - L + 1;
    localparam int MW = W + H;
    localparam int PW = 2 * W;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LO,
        PH_HI,
        PH_SUM
    } t_phase;

    t_phase                r_phase;
    logic                  r_done;
    logic signed [W-1:0]   r_a;
    logic signed [W-1:0]   r_b;
    logic signed [MW-1:0]  r_lo;
    logic signed [MW-1:0]  r_hi;
    logic signed [PW-1:0]  r_p;

    logic signed [H-1:0]   w_op;
    logic signed [MW-1:0]  w_mp;
    logic signed [PW-1:0]  w_lo_ext;
    logic signed [PW-1:0]  w_hi_ext;

    always_comb begin
        // low half is unsigned, high half carries the sign
        if (r_phase == PH_LO) begin
            w_op = signed'({{(H - L){1'b0}}, r_b[L-1:0]});
        end else begin
            w_op = signed'({r_b[W-1], r_b[W-1:L]});
        end
        w_mp     = MW'(r_a) * MW'(w_op);
        w_lo_ext = PW'(r_lo);
        w_hi_ext = PW'(r_hi);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_start) begin
                        r_a     <= i_a;
                        r_b     <= i_b;
                        r_phase <= PH_LO;
                    end
                end
                PH_LO: begin
                    r_lo    <= w_mp;
                    r_phase <= PH_HI;
                end
                PH_HI: begin
                    r_hi    <= w_mp;
                    r_phase <= PH_SUM;
                end
                PH_SUM: begin
                    r_p     <= (w_hi_ext <<< L) + w_lo_ext;
                    r_done  <= 1'b1;
                    r_phase <= PH_IDLE;
                end
                default: r_phase <= PH_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_p    = r_p;

endmodule
`default_nettype wire

// ----- hdl/qjet_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// qjet_cell
// One ring cell: holds one component of z and of C, hands them to its
// neighbour, and at the head forms floor(x / 2^F) + c with saturation.
// ----------------------------------------------------------------------------
module qjet_cell #(
    parameter int COMPONENT_WIDTH = 32,
    parameter int FRACTION_BITS   = 16
) (
    input  logic                                i_clk,
    input  qjet_pkg::t_ring_ctrl                i_ctrl,
    input  logic [qjet_pkg::FIELD_W-1:0]        i_load_z,
    input  logic [qjet_pkg::FIELD_W-1:0]        i_load_c,
    input  logic signed [COMPONENT_WIDTH-1:0]   i_nb_z,
    input  logic signed [COMPONENT_WIDTH-1:0]   i_nb_c,
    input  logic signed [2*COMPONENT_WIDTH:0]   i_x,
    output logic signed [COMPONENT_WIDTH-1:0]   o_z,
    output logic signed [COMPONENT_WIDTH-1:0]   o_hand_z,
    output logic signed [COMPONENT_WIDTH-1:0]   o_hand_c
);

    localparam int W  = COMPONENT_WIDTH;
    localparam int F  = FRACTION_BITS;
    localparam int FW = qjet_pkg::FIELD_W;
    localparam int XW = 2 * W + 1;
    localparam int QW = XW - F;
    localparam int SW = ((QW > W) ? QW : W) + 1;
    localparam int LW = ((W > FW) ? W : FW) + 1;
    localparam int GW = (SW > LW) ? SW : LW;

    localparam logic signed [W-1:0] MAXV = {1'b0, {(W - 1){1'b1}}};
    localparam logic signed [W-1:0] MINV = {1'b1, {(W - 1){1'b0}}};

    logic signed [W-1:0]  r_z;
    logic signed [W-1:0]  r_c;

    logic signed [QW-1:0] w_q;
    logic signed [SW-1:0] w_sum;

    function automatic logic signed [W-1:0] f_clip(input logic signed [GW-1:0] v);
        logic [GW-W:0] hi;
        hi = v[GW-1:W-1];
        if ((&hi) || !(|hi)) begin
            f_clip = v[W-1:0];
        end else if (v[GW-1]) begin
            f_clip = MINV;
        end else begin
            f_clip = MAXV;
        end
    endfunction

    always_comb begin
        // floor shift is just dropping the fraction bits
        w_q      = i_x[XW-1:F];
        w_sum    = SW'(w_q) + SW'(r_c);
        o_hand_z = i_ctrl.upd ? f_clip(GW'(w_sum)) : r_z;
        o_hand_c = r_c;
        o_z      = r_z;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_z <= f_clip(GW'(signed'(i_load_z)));
            r_c <= f_clip(GW'(signed'(i_load_c)));
        end else if (i_ctrl.shift) begin
            r_z <= i_nb_z;
            r_c <= i_nb_c;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/quaternion_julia_escape_time.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_julia_escape_time
// Escape-time test of z = z*z + C over quaternions in signed fixed point.
// ----------------------------------------------------------------------------
// One pixel constant C is taken at a time; the input stalls until its escape
// count has moved into the output register, and a finished count may wait
// there while the next pixel is already being worked on. The four components
// of z and C sit in a ring of four cells that rotates through one shared
// multiplier, which forms each product in two half-width passes and a
// recombine. A step costs 4 squares and 3 cross products. |z|^2 of the new
// z is taken from the squares that also feed the next step's real part.
// ----------------------------------------------------------------------------
module quaternion_julia_escape_time #(
    parameter int COMPONENT_WIDTH = 32,
    parameter int FRACTION_BITS   = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // pixel constant
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [qjet_pkg::FIELD_W-1:0]          i_c_real,
    input  logic [qjet_pkg::FIELD_W-1:0]          i_c_i,
    input  logic [qjet_pkg::FIELD_W-1:0]          i_c_j,
    input  logic [qjet_pkg::FIELD_W-1:0]          i_c_k,
    // escape count
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [qjet_pkg::LIMIT_W-1:0]          o_escape_count,
    // register writes
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [qjet_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [qjet_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int W  = COMPONENT_WIDTH;
    localparam int PW = 2 * W;
    localparam int XW = 2 * W + 1;
    localparam int CW = (XW > qjet_pkg::R2_W) ? XW : qjet_pkg::R2_W;
    localparam int NP = qjet_pkg::QUAT_PARTS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ_GO,
        ST_SQ_WAIT,
        ST_CHECK,
        ST_UP_GO,
        ST_UP_WAIT,
        ST_FIN
    } t_state;

    // registers
    logic [qjet_pkg::FIELD_W-1:0]   r_start [NP];
    logic [qjet_pkg::LIMIT_W-1:0]   r_limit;
    logic [qjet_pkg::RADIUS_W-1:0]  r_radius;

    t_state                         r_state;
    logic [qjet_pkg::QIDX_W-1:0]    r_idx;
    logic [qjet_pkg::LIMIT_W-1:0]   r_step;
    logic signed [XW-1:0]           r_re;
    logic [XW-1:0]                  r_mod;
    logic [qjet_pkg::R2_W-1:0]      r_r2;
    logic signed [W-1:0]            r_zr;
    logic [qjet_pkg::LIMIT_W-1:0]   r_res;
    logic                           r_out_valid;
    logic [qjet_pkg::LIMIT_W-1:0]   r_out_count;

    logic                           w_in_accept;
    logic                           w_mul_start;
    logic                           w_mul_done;
    logic signed [W-1:0]            w_mul_b;
    logic signed [PW-1:0]           w_prod;
    logic signed [XW-1:0]           w_x;
    logic [qjet_pkg::R2_W-1:0]      w_r2;
    logic                           w_escaped;
    logic                           w_at_limit;
    logic                           w_cont;
    logic                           w_load;
    logic                           w_shift;
    logic                           w_upd;

    logic [qjet_pkg::FIELD_W-1:0]   w_c_in   [NP];
    logic signed [W-1:0]            w_z      [NP];
    logic signed [W-1:0]            w_hand_z [NP];
    logic signed [W-1:0]            w_hand_c [NP];
    qjet_pkg::t_ring_ctrl           w_ctrl   [NP];

    assign w_c_in[0] = i_c_real;
    assign w_c_in[1] = i_c_i;
    assign w_c_in[2] = i_c_j;
    assign w_c_in[3] = i_c_k;

    // ------------------------------------------------------------------------
    // register port
    // ------------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int n = 0; n < NP; n++) begin
                r_start[n] <= qjet_pkg::START_RESET;
            end
            r_limit  <= qjet_pkg::LIMIT_RESET;
            r_radius <= qjet_pkg::RADIUS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                qjet_pkg::CFG_START_REAL: r_start[0] <= i_cfg_data;
                qjet_pkg::CFG_START_I:    r_start[1] <= i_cfg_data;
                qjet_pkg::CFG_START_J:    r_start[2] <= i_cfg_data;
                qjet_pkg::CFG_START_K:    r_start[3] <= i_cfg_data;
                qjet_pkg::CFG_ITER_LIMIT: r_limit    <= i_cfg_data[qjet_pkg::LIMIT_W-1:0];
                qjet_pkg::CFG_ESC_RADIUS: r_radius   <= i_cfg_data[qjet_pkg::RADIUS_W-1:0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // ring of component cells, head is cell 0
    // ------------------------------------------------------------------------
    for (genvar k = 0; k < NP; k++) begin : g_ring
        assign w_ctrl[k].load  = w_load;
        assign w_ctrl[k].shift = w_shift;
        assign w_ctrl[k].upd   = (k == 0) ? w_upd : 1'b0;

        qjet_cell #(
            .COMPONENT_WIDTH (COMPONENT_WIDTH),
            .FRACTION_BITS   (FRACTION_BITS)
        ) u_cell (
            .i_clk    (i_clk),
            .i_ctrl   (w_ctrl[k]),
            .i_load_z (r_start[k]),
            .i_load_c (w_c_in[k]),
            .i_nb_z   (w_hand_z[(k + 1) % NP]),
            .i_nb_c   (w_hand_c[(k + 1) % NP]),
            .i_x      (w_x),
            .o_z      (w_z[k]),
            .o_hand_z (w_hand_z[k]),
            .o_hand_c (w_hand_c[k])
        );
    end

    qjet_mul #(
        .COMPONENT_WIDTH (COMPONENT_WIDTH)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_z[0]),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_p     (w_prod)
    );

    // ------------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------------
    always_comb begin
        o_in_stall  = (r_state != ST_IDLE);
        w_in_accept = i_in_valid && !o_in_stall;
        w_load      = w_in_accept;
        w_mul_start = (r_state == ST_SQ_GO) || (r_state == ST_UP_GO);
        w_mul_b     = (r_state == ST_SQ_GO) ? w_z[0] : r_zr;
        w_r2        = qjet_pkg::R2_W'(r_radius) * qjet_pkg::R2_W'(r_radius);

        // test only once a step has been run
        w_escaped   = (r_step != '0) && (CW'(r_mod) > CW'(r_r2));
        w_at_limit  = (r_step == r_limit);
        w_cont      = !w_escaped && !w_at_limit;

        w_upd       = (r_state == ST_CHECK) || (r_state == ST_UP_WAIT);
        w_shift     = (((r_state == ST_SQ_WAIT) || (r_state == ST_UP_WAIT)) && w_mul_done)
                      || ((r_state == ST_CHECK) && w_cont);

        // real part uses the square sum, the others twice the cross product
        if (r_state == ST_CHECK) begin
            w_x = r_re;
        end else begin
            w_x = signed'({w_prod, 1'b0});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // drop a taken beat unless a finished count replaces it
            if (r_out_valid && !i_out_stall && (r_state != ST_FIN)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_accept) begin
                        r_idx   <= qjet_pkg::PART_REAL;
                        r_step  <= '0;
                        r_re    <= '0;
                        r_mod   <= '0;
                        r_r2    <= w_r2;
                        r_state <= ST_SQ_GO;
                    end
                end
                ST_SQ_GO: begin
                    r_state <= ST_SQ_WAIT;
                end
                ST_SQ_WAIT: begin
                    if (w_mul_done) begin
                        r_mod <= r_mod + {1'b0, w_prod};
                        if (r_idx == qjet_pkg::PART_REAL) begin
                            r_re <= r_re + XW'(w_prod);
                        end else begin
                            r_re <= r_re - XW'(w_prod);
                        end
                        r_idx <= r_idx + qjet_pkg::QIDX_W'(1);
                        if (r_idx == qjet_pkg::PART_LAST) begin
                            r_state <= ST_CHECK;
                        end else begin
                            r_state <= ST_SQ_GO;
                        end
                    end
                end
                ST_CHECK: begin
                    if (w_escaped) begin
                        r_res   <= r_step - qjet_pkg::LIMIT_W'(1);
                        r_state <= ST_FIN;
                    end else if (w_at_limit) begin
                        r_res   <= '0;
                        r_state <= ST_FIN;
                    end else begin
                        // keep the old real part for the cross products
                        r_zr    <= w_z[0];
                        r_idx   <= qjet_pkg::PART_I;
                        r_state <= ST_UP_GO;
                    end
                end
                ST_UP_GO: begin
                    r_state <= ST_UP_WAIT;
                end
                ST_UP_WAIT: begin
                    if (w_mul_done) begin
                        if (r_idx == qjet_pkg::PART_LAST) begin
                            r_idx   <= qjet_pkg::PART_REAL;
                            r_step  <= r_step + qjet_pkg::LIMIT_W'(1);
                            r_re    <= '0;
                            r_mod   <= '0;
                            r_state <= ST_SQ_GO;
                        end else begin
                            r_idx   <= r_idx + qjet_pkg::QIDX_W'(1);
                            r_state <= ST_UP_GO;
                        end
                    end
                end
                ST_FIN: begin
                    // hold until the output register is free
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_count <= r_res;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_escape_count = r_out_count;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> (r_state == ST_SQ_GO))
        else $error("accepted beat did not start the square pass");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> ((r_state == ST_SQ_WAIT) || (r_state == ST_UP_WAIT)))
        else $error("product finished outside a wait state");

    a_check_at_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHECK) |-> (r_idx == qjet_pkg::PART_REAL))
        else $error("ring not back at the real part on check");

    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_FIN))
        else $error("output beat raised without a finished item");

endmodule
`default_nettype wire
